// File: hdl/mec_pkg.sv
// shared constants, types and register map for the mandelbrot escape colorizer
// no dependencies; used by every module of the block
package mec_pkg;

  localparam int ITER_LIMIT = 100;
  localparam int FRAC_BITS  = 28;

  localparam int C_W        = 32;
  localparam int COL_W      = 8;
  localparam int ITER_OUT_W = 7;
  localparam int DATA_W     = 32;
  localparam int REG_N      = 6;
  localparam int ADDR_W     = $clog2(4 * REG_N);
  localparam int IDX_W      = ADDR_W - 2;

  // integer bits of c (with sign); z may reach 4 plus the size of c after a step
  localparam int C_INT      = C_W - FRAC_BITS;
  localparam int Z_W        = FRAC_BITS + ((C_INT > 3) ? C_INT : 3) + 1;
  // multiplier operand: enough for |z| <= 2
  localparam int OP_W       = FRAC_BITS + 3;
  localparam int ACC_W      = (2 * OP_W > FRAC_BITS + Z_W) ? 2 * OP_W : FRAC_BITS + Z_W;

  localparam int CNT_W      = $clog2(ITER_LIMIT + 1);

  // color blend: floor(num / SPAN) by reciprocal multiply and one correction
  localparam int SPAN       = ITER_LIMIT - 1;
  localparam int SPAN_W     = $clog2(SPAN + 1);
  localparam int NUM_W      = COL_W + SPAN_W;
  localparam int RECIP_SH   = NUM_W + SPAN_W;
  localparam int RECIP_W    = NUM_W + 2;
  localparam int PRD_W      = NUM_W + RECIP_W;
  localparam int QE_W       = COL_W + 1;
  localparam int CHK_W      = QE_W + SPAN_W;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(SPAN) - 64'd1) / 64'(SPAN));

  localparam logic signed [Z_W-1:0]   Z_TWO    = Z_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [ACC_W-1:0] ACC_FOUR = ACC_W'(1) << (2 * FRAC_BITS + 2);

  localparam logic [COL_W-1:0] RST_START_RED   = 8'd194;
  localparam logic [COL_W-1:0] RST_START_GREEN = 8'd252;
  localparam logic [COL_W-1:0] RST_START_BLUE  = 8'd199;
  localparam logic [COL_W-1:0] RST_END_RED     = 8'd140;
  localparam logic [COL_W-1:0] RST_END_GREEN   = 8'd10;
  localparam logic [COL_W-1:0] RST_END_BLUE    = 8'd196;

  typedef enum logic [IDX_W-1:0] {
    REG_START_RED   = 3'd0,
    REG_START_GREEN = 3'd1,
    REG_START_BLUE  = 3'd2,
    REG_END_RED     = 3'd3,
    REG_END_GREEN   = 3'd4,
    REG_END_BLUE    = 3'd5
  } reg_idx_t;

  // lane 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [2:0][COL_W-1:0] first;
    logic [2:0][COL_W-1:0] last;
  } mec_palette_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic col_num;
    logic col_div;
    logic col_fix;
  } mec_cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
  } mec_stat_t;

endpackage

// File: hdl/mec_regs.sv
// color configuration registers behind the apb-style port
// depends on mec_pkg
module mec_regs import mec_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output mec_palette_t        palette
);

  logic [2:0][COL_W-1:0] first_r, first_nxt;
  logic [2:0][COL_W-1:0] last_r, last_nxt;
  logic                  wr_en;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    if (wr_en) begin
      case (idx)
        REG_START_RED:   first_nxt[0] = pwdata[COL_W-1:0];
        REG_START_GREEN: first_nxt[1] = pwdata[COL_W-1:0];
        REG_START_BLUE:  first_nxt[2] = pwdata[COL_W-1:0];
        REG_END_RED:     last_nxt[0]  = pwdata[COL_W-1:0];
        REG_END_GREEN:   last_nxt[1]  = pwdata[COL_W-1:0];
        REG_END_BLUE:    last_nxt[2]  = pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= {RST_START_BLUE, RST_START_GREEN, RST_START_RED};
      last_r  <= {RST_END_BLUE, RST_END_GREEN, RST_END_RED};
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_START_RED:   prdata = DATA_W'(first_r[0]);
      REG_START_GREEN: prdata = DATA_W'(first_r[1]);
      REG_START_BLUE:  prdata = DATA_W'(first_r[2]);
      REG_END_RED:     prdata = DATA_W'(last_r[0]);
      REG_END_GREEN:   prdata = DATA_W'(last_r[1]);
      REG_END_BLUE:    prdata = DATA_W'(last_r[2]);
      default:         prdata = '0;
    endcase
  end

  assign palette.first = first_r;
  assign palette.last  = last_r;

endmodule

// File: hdl/mec_dp.sv
// datapath: z iteration with three parallel multipliers, escape test, color blend
// depends on mec_pkg; driven by mec_ctrl through mec_cmd_t
module mec_dp import mec_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mec_cmd_t               cmd,
  input  mec_palette_t           palette,
  input  logic signed [C_W-1:0]  in_c_real,
  input  logic signed [C_W-1:0]  in_c_imag,
  output mec_stat_t              stat,
  output logic [ITER_OUT_W-1:0]  out_iterations,
  output logic                   out_inside_set,
  output logic [COL_W-1:0]       out_red,
  output logic [COL_W-1:0]       out_green,
  output logic [COL_W-1:0]       out_blue
);

  logic signed [C_W-1:0]   cr_r, ci_r;
  logic signed [Z_W-1:0]   za_r, zb_r, za_nxt, zb_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [ACC_W-1:0] rr_r, ii_r, ri_r;
  logic signed [ACC_W-1:0] rr_nxt, ii_nxt, ri_nxt;
  logic                    big_r, big_nxt;
  logic signed [OP_W-1:0]  za_op, zb_op;
  logic signed [ACC_W-1:0] cr_sc, ci_sc, re_sum, im_sum, mag_sum;

  logic [2:0][NUM_W-1:0]   num_r, num_nxt;
  logic [2:0][QE_W-1:0]    qe_r, qe_nxt;
  logic [2:0][COL_W-1:0]   col_nxt;
  logic [SPAN_W-1:0]       n_s, rem_s;
  logic                    at_limit;
  logic [PRD_W-1:0]        prd;
  logic [CHK_W-1:0]        chk;
  logic [COL_W-1:0]        red_r, green_r, blue_r;
  logic [ITER_OUT_W-1:0]   iter_r;
  logic                    inside_r;

  // operands only matter while |z| <= 2, which the range flag covers
  assign za_op  = za_r[OP_W-1:0];
  assign zb_op  = zb_r[OP_W-1:0];
  assign rr_nxt = ACC_W'(za_op) * ACC_W'(za_op);
  assign ii_nxt = ACC_W'(zb_op) * ACC_W'(zb_op);
  assign ri_nxt = ACC_W'(za_op) * ACC_W'(zb_op);
  assign big_nxt = (za_r > Z_TWO) || (za_r < -Z_TWO) ||
                   (zb_r > Z_TWO) || (zb_r < -Z_TWO);

  assign cr_sc   = ACC_W'(cr_r) <<< FRAC_BITS;
  assign ci_sc   = ACC_W'(ci_r) <<< FRAC_BITS;
  assign mag_sum = rr_r + ii_r;
  assign re_sum  = rr_r - ii_r + cr_sc;
  assign im_sum  = (ri_r <<< 1) + ci_sc;
  // arithmetic shift down by the fraction bits
  assign za_nxt  = re_sum[FRAC_BITS +: Z_W];
  assign zb_nxt  = im_sum[FRAC_BITS +: Z_W];

  assign stat.escape = big_r || (mag_sum > ACC_FOUR);
  assign stat.last   = (cnt_r == CNT_W'(ITER_LIMIT - 1));

  assign at_limit = (cnt_r == CNT_W'(ITER_LIMIT));
  assign n_s      = SPAN_W'(cnt_r);
  assign rem_s    = SPAN_W'(SPAN) - n_s;

  always_comb begin
    prd = '0;
    chk = '0;
    for (int k = 0; k < 3; k++) begin
      num_nxt[k] = NUM_W'(palette.first[k]) * NUM_W'(rem_s) +
                   NUM_W'(palette.last[k]) * NUM_W'(n_s);
      prd        = PRD_W'(num_r[k]) * PRD_W'(RECIP);
      qe_nxt[k]  = prd[RECIP_SH +: QE_W];
      // estimate is exact or one high
      chk        = CHK_W'(qe_r[k]) * CHK_W'(SPAN);
      if (chk > CHK_W'(num_r[k])) begin
        col_nxt[k] = COL_W'(qe_r[k] - QE_W'(1));
      end else begin
        col_nxt[k] = COL_W'(qe_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r <= in_c_real;
      ci_r <= in_c_imag;
      za_r <= '0;
      zb_r <= '0;
    end else if (cmd.step) begin
      za_r <= za_nxt;
      zb_r <= zb_nxt;
    end
    if (cmd.mul) begin
      rr_r  <= rr_nxt;
      ii_r  <= ii_nxt;
      ri_r  <= ri_nxt;
      big_r <= big_nxt;
    end
    if (cmd.col_num) begin
      num_r <= num_nxt;
    end
    if (cmd.col_div) begin
      qe_r <= qe_nxt;
    end
    if (cmd.col_fix) begin
      iter_r   <= ITER_OUT_W'(cnt_r);
      inside_r <= at_limit;
      red_r    <= at_limit ? '0 : col_nxt[0];
      green_r  <= at_limit ? '0 : col_nxt[1];
      blue_r   <= at_limit ? '0 : col_nxt[2];
    end
  end

  assign out_iterations = iter_r;
  assign out_inside_set = inside_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ITER_LIMIT))
    else $error("iteration count beyond limit");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("count did not advance on step");

endmodule

// File: hdl/mec_ctrl.sv
// controller: sequences load, multiply, update and the three color steps
// depends on mec_pkg; commands mec_dp, reads its escape and last status
module mec_ctrl import mec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  mec_stat_t stat,
  output mec_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_CNUM,
    ST_CDIV,
    ST_CFIX
  } state_t;

  state_t state_r;
  logic   busy_r, valid_r;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: cmd.load    = accept;
      ST_MUL:  cmd.mul     = 1'b1;
      ST_UPD:  cmd.step    = !stat.escape;
      ST_CNUM: cmd.col_num = 1'b1;
      ST_CDIV: cmd.col_div = 1'b1;
      ST_CFIX: cmd.col_fix = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_MUL;
            busy_r  <= 1'b1;
          end
        end
        ST_MUL: state_r <= ST_UPD;
        ST_UPD: begin
          if (stat.escape || stat.last) begin
            state_r <= ST_CNUM;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_CNUM: state_r <= ST_CDIV;
        ST_CDIV: state_r <= ST_CFIX;
        ST_CFIX: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
          valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_step_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (state_r == ST_UPD) && !stat.escape)
    else $error("step issued outside update or on escape");

endmodule

// File: hdl/mandelbrot_escape_colorizer_unit.sv
// top level of the mandelbrot escape-time colorizer
// depends on mec_pkg, mec_regs, mec_ctrl, mec_dp
//
//  channel   ports                                       handshake
//  request   in_c_real, in_c_imag                        start && !busy
//  result    out_iterations, out_inside_set, out_red,    out_valid, one cycle
//            out_green, out_blue
//  config    psel, penable, pwrite, paddr, pwdata,       psel/penable/pready
//            prdata, pready
//
// busy stays high while a point runs; each iteration is one multiply state (two squarings
// and the cross product in parallel) and one add/compare/update state; an escaping point
// takes one more such pair to find the escape, then every point passes three color states
// out_valid rises the cycle busy drops and a new request can be taken then
// synchronous active-low reset; palette registers return to their defaults
// the receiver cannot stall: each result is shown for exactly one cycle
module mandelbrot_escape_colorizer_unit import mec_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [C_W-1:0]  in_c_real,
  input  logic signed [C_W-1:0]  in_c_imag,
  output logic                   out_valid,
  output logic [ITER_OUT_W-1:0]  out_iterations,
  output logic                   out_inside_set,
  output logic [COL_W-1:0]       out_red,
  output logic [COL_W-1:0]       out_green,
  output logic [COL_W-1:0]       out_blue,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  mec_palette_t palette;
  mec_cmd_t     cmd;
  mec_stat_t    stat;

  mec_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .palette (palette)
  );

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mec_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .palette        (palette),
    .in_c_real      (in_c_real),
    .in_c_imag      (in_c_imag),
    .stat           (stat),
    .out_iterations (out_iterations),
    .out_inside_set (out_inside_set),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for mandelbrot_escape_colorizer_unit: points go in over the
// start/busy port, results are checked against a bit-exact escape-time predictor
// depends on mec_pkg and the rtl under hdl/
module tb;
  import mec_pkg::*;

  localparam int ONE   = 1 << FRAC_BITS;
  localparam int LIMIT = 2000000;
  localparam int DRAIN = 2 * ITER_LIMIT + 8;

  typedef struct {
    logic signed [C_W-1:0]  c_re;
    logic signed [C_W-1:0]  c_im;
    logic [ITER_OUT_W-1:0]  iterations;
    logic                   inside_set;
    logic [COL_W-1:0]       red;
    logic [COL_W-1:0]       green;
    logic [COL_W-1:0]       blue;
  } pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic signed [C_W-1:0] in_c_real;
  logic signed [C_W-1:0] in_c_imag;
  logic                  out_valid;
  logic [ITER_OUT_W-1:0] out_iterations;
  logic                  out_inside_set;
  logic [COL_W-1:0]      out_red;
  logic [COL_W-1:0]      out_green;
  logic [COL_W-1:0]      out_blue;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  pixel_t                pending_pixels[$];
  pixel_t                due_px;
  logic [COL_W-1:0]      palette_regs[REG_N];
  logic signed [C_W-1:0] deep_real;
  int                    mismatch_count;
  int                    cycle_count;

  mandelbrot_escape_colorizer_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_c_real(in_c_real), .in_c_imag(in_c_imag),
    .out_valid(out_valid), .out_iterations(out_iterations),
    .out_inside_set(out_inside_set), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // exact escape count: z kept at 64 bits, products at 128
  function automatic int escape_count(logic signed [C_W-1:0] cr, logic signed [C_W-1:0] ci);
    logic signed [63:0]  za, zb;
    logic signed [127:0] rr, ii, zab, re, im, cr_s, ci_s, limit4;
    int n;
    za = '0;
    zb = '0;
    n = 0;
    cr_s = 128'(cr);
    ci_s = 128'(ci);
    cr_s = cr_s <<< FRAC_BITS;
    ci_s = ci_s <<< FRAC_BITS;
    limit4 = 128'sd1 <<< (2 * FRAC_BITS + 2);
    while (n < ITER_LIMIT) begin
      rr = 128'(za) * 128'(za);
      ii = 128'(zb) * 128'(zb);
      if (rr + ii > limit4) break;
      zab = 128'(za) * 128'(zb);
      re = rr - ii + cr_s;
      im = (zab <<< 1) + ci_s;
      za = 64'(re >>> FRAC_BITS);
      zb = 64'(im >>> FRAC_BITS);
      n++;
    end
    return n;
  endfunction

  function automatic logic [COL_W-1:0] blend_channel(logic [COL_W-1:0] from, logic [COL_W-1:0] to,
                                                     int n);
    int span;
    span = ITER_LIMIT - 1;
    return COL_W'((int'(from) * (span - n) + int'(to) * n) / span);
  endfunction

  function automatic pixel_t predict_pixel(logic signed [C_W-1:0] cr, logic signed [C_W-1:0] ci);
    pixel_t px;
    int n;
    n = escape_count(cr, ci);
    px.c_re = cr;
    px.c_im = ci;
    px.iterations = ITER_OUT_W'(n);
    px.inside_set = (n == ITER_LIMIT);
    if (px.inside_set) begin
      px.red = '0;
      px.green = '0;
      px.blue = '0;
    end else begin
      px.red   = blend_channel(palette_regs[REG_START_RED], palette_regs[REG_END_RED], n);
      px.green = blend_channel(palette_regs[REG_START_GREEN], palette_regs[REG_END_GREEN], n);
      px.blue  = blend_channel(palette_regs[REG_START_BLUE], palette_regs[REG_END_BLUE], n);
    end
    return px;
  endfunction

  // walks right from the cusp at 0.25 until the count drops to the target
  function automatic logic signed [C_W-1:0] real_for_count(int target);
    logic signed [C_W-1:0] re;
    int guard;
    re = ONE / 4;
    guard = 0;
    while (escape_count(re, '0) > target && guard < 400000) begin
      re += 256;
      guard++;
    end
    return re;
  endfunction

  function automatic logic [DATA_W-1:0] padded(logic [COL_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = $urandom;
    r[COL_W-1:0] = v;
    return r;
  endfunction

  function automatic void pick_region_point(output logic signed [C_W-1:0] re,
                                            output logic signed [C_W-1:0] im);
    re = $signed($urandom_range(0, 3 * ONE)) - (9 * (ONE / 4));
    im = $signed($urandom_range(0, 3 * ONE)) - (3 * ONE / 2);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("[mandelbrot_escape_colorizer_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        due_px = pending_pixels.pop_front();
        if (out_iterations !== due_px.iterations)
          report_mismatch($sformatf("iterations %0d want %0d, c=(%h,%h)", out_iterations,
                                    due_px.iterations, due_px.c_re, due_px.c_im));
        if (out_inside_set !== due_px.inside_set)
          report_mismatch($sformatf("inside_set %b want %b, c=(%h,%h)", out_inside_set,
                                    due_px.inside_set, due_px.c_re, due_px.c_im));
        if (out_red !== due_px.red)
          report_mismatch($sformatf("red %0d want %0d, c=(%h,%h)", out_red, due_px.red,
                                    due_px.c_re, due_px.c_im));
        if (out_green !== due_px.green)
          report_mismatch($sformatf("green %0d want %0d, c=(%h,%h)", out_green, due_px.green,
                                    due_px.c_re, due_px.c_im));
        if (out_blue !== due_px.blue)
          report_mismatch($sformatf("blue %0d want %0d, c=(%h,%h)", out_blue, due_px.blue,
                                    due_px.c_re, due_px.c_im));
      end
    end
  end

  // leaves start high on return so a following request goes out back to back
  task automatic send_point(input logic signed [C_W-1:0] re, input logic signed [C_W-1:0] im);
    start <= 1'b1;
    in_c_real <= re;
    in_c_imag <= im;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.push_back(predict_pixel(re, im));
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_all_done();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < REG_N) palette_regs[idx] = data[COL_W-1:0];
  endtask

  task automatic check_reg(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== DATA_W'(palette_regs[idx]))
      report_mismatch($sformatf("register %0d reads %h want %h", idx, rd, palette_regs[idx]));
  endtask

  // block must be idle: writes every register with junk above bit 7, pokes the
  // unmapped addresses, then reads the six registers back
  task automatic set_palette(input logic [COL_W-1:0] sr, input logic [COL_W-1:0] sg,
                             input logic [COL_W-1:0] sb, input logic [COL_W-1:0] er,
                             input logic [COL_W-1:0] eg, input logic [COL_W-1:0] eb);
    write_reg(REG_START_RED, padded(sr));
    write_reg(REG_START_GREEN, padded(sg));
    write_reg(REG_START_BLUE, padded(sb));
    write_reg(REG_END_RED, padded(er));
    write_reg(REG_END_GREEN, padded(eg));
    write_reg(REG_END_BLUE, padded(eb));
    write_reg(IDX_W'(REG_N), $urandom);
    write_reg(IDX_W'(REG_N + 1), $urandom);
    for (int i = 0; i < REG_N; i++) check_reg(IDX_W'(i));
  endtask

  task automatic test_register_reset();
    for (int i = 0; i < REG_N; i++) check_reg(IDX_W'(i));
  endtask

  task automatic test_corner_points();
    send_point('0, '0);
    send_point(32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh80000000);
    send_point(32'sh80000000, 32'sh7fffffff);
    send_point('0, 32'sh80000000);
    send_point(32'sh80000000, '0);
    // tip of the set: |z|^2 lands exactly on 4 after every step
    send_point(-2 * ONE, '0);
    send_point(2 * ONE, '0);
    send_point(2 * ONE + 1, '0);
    send_point(ONE / 4, '0);
    send_point('0, ONE);
    send_point(-ONE, '0);
    send_point(-3 * ONE / 4, ONE / 10);
    send_point(1, -1);
    send_point(ONE / 2, ONE / 2);
    send_point(3 * ONE, -ONE);
    wait_all_done();
  endtask

  task automatic test_count_boundaries();
    logic signed [C_W-1:0] re;
    deep_real = real_for_count(ITER_LIMIT - 1);
    send_point(deep_real, '0);
    send_point(deep_real, 1);
    send_point(deep_real - 256, '0);
    re = real_for_count(ITER_LIMIT - 2);
    send_point(re, '0);
    re = real_for_count(ITER_LIMIT / 2);
    send_point(re, -1);
    wait_all_done();
  endtask

  task automatic palette_burst();
    logic signed [C_W-1:0] re, im;
    for (int i = 0; i < 28; i++) begin
      case (i % 4)
        0: begin
          pick_region_point(re, im);
          send_point(re, im);
        end
        1: send_point(deep_real, '0);
        2: send_point(3 * ONE, '0);
        default: send_point(-ONE / 2, ONE / 4);
      endcase
    end
    wait_all_done();
  endtask

  task automatic test_palette_extremes();
    set_palette('0, '0, '0, '0, '0, '0);
    palette_burst();
    set_palette('1, '1, '1, '0, '0, '0);
    palette_burst();
    set_palette('0, '0, '0, '1, '1, '1);
    palette_burst();
    set_palette(COL_W'($urandom), COL_W'($urandom), COL_W'($urandom),
                COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
    palette_burst();
  endtask

  task automatic test_random_points(input int count);
    logic signed [C_W-1:0] re, im;
    int burst_left, k;
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // drain fully, then move to a fresh palette
        wait_all_done();
        set_palette(COL_W'($urandom), COL_W'($urandom), COL_W'($urandom),
                    COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
      end
      k = $urandom_range(0, 99);
      if (k < 55) begin
        pick_region_point(re, im);
      end else if (k < 65) begin
        re = deep_real + int'($urandom_range(0, 65535)) - 32768;
        im = int'($urandom_range(0, 16383)) - 8192;
      end else if (k < 75) begin
        re = -3 * ONE / 4 + int'($urandom_range(0, ONE / 32)) - ONE / 64;
        im = ONE / 10 + int'($urandom_range(0, ONE / 32)) - ONE / 64;
      end else begin
        re = $urandom;
        im = $urandom;
      end
      send_point(re, im);
      burst_left--;
      if (burst_left == 0) begin
        k = $urandom_range(0, 99);
        if (k < 75) idle_gap($urandom_range(1, 6));
        else if (k < 95) idle_gap($urandom_range(7, 40));
        else idle_gap($urandom_range(41, 2 * ITER_LIMIT + 30));
        burst_left = $urandom_range(1, 20);
      end
    end
    wait_all_done();
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    deep_real = ONE / 4;
    palette_regs[REG_START_RED]   = RST_START_RED;
    palette_regs[REG_START_GREEN] = RST_START_GREEN;
    palette_regs[REG_START_BLUE]  = RST_START_BLUE;
    palette_regs[REG_END_RED]     = RST_END_RED;
    palette_regs[REG_END_GREEN]   = RST_END_GREEN;
    palette_regs[REG_END_BLUE]    = RST_END_BLUE;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_c_real <= '0;
    in_c_imag <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_corner_points();
    test_count_boundaries();
    test_palette_extremes();
    test_random_points(1500);

    wait_all_done();
    if (mismatch_count == 0) begin
      $display("[mandelbrot_escape_colorizer_unit] OK");
    end else begin
      $display("[mandelbrot_escape_colorizer_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mec_pkg.sv
hdl/mec_regs.sv
hdl/mec_dp.sv
hdl/mec_ctrl.sv
hdl/mandelbrot_escape_colorizer_unit.sv
sim/tb.sv
